// ===== rtl/core/ecwc_pkg.sv =====
// ----------------------------------------------------------------------------
// ecwc_pkg
// Shared codes for the extent coalesce and window carve core: command codes,
// control register indexes and the piece set carried by the carve stage.
// ----------------------------------------------------------------------------
package ecwc_pkg;

   typedef enum logic {
      CMD_EXTENT = 1'b0,
      CMD_FLUSH  = 1'b1
   } cmd_type;

   localparam int CSR_INDEX_BITS = 2;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_TARGET_BLOCK  = 2'd0,
      CSR_WINDOW_OFFSET = 2'd1,
      CSR_WINDOW_LENGTH = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic head;
      logic tail;
   } piece_set_type;

endpackage

// ===== rtl/core/ecwc_csr.sv =====
// ----------------------------------------------------------------------------
// ecwc_csr
// Control registers: target block, window offset and window length, plus a
// registered window end (offset + length, one bit wider).
// ----------------------------------------------------------------------------
module ecwc_csr #(
   parameter int OFFSET_BITS = 48,
   parameter int BLOCK_BITS  = 32
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      csr_valid,
   output logic                                      csr_ready,
   input  logic [ecwc_pkg::CSR_INDEX_BITS-1:0]       csr_index,
   input  logic [(BLOCK_BITS > OFFSET_BITS ? BLOCK_BITS : OFFSET_BITS)-1:0] csr_wdata,
   output logic [BLOCK_BITS-1:0]                     target_block,
   output logic [OFFSET_BITS-1:0]                    window_offset,
   output logic [OFFSET_BITS:0]                      window_end
);

   logic [BLOCK_BITS-1:0]  target_block_ff,  target_block_in;
   logic [OFFSET_BITS-1:0] window_offset_ff, window_offset_in;
   logic [OFFSET_BITS-1:0] window_length_ff, window_length_in;
   logic [OFFSET_BITS:0]   window_end_ff,    window_end_in;

   assign csr_ready = 1'b1;

   always_comb begin
      target_block_in  = target_block_ff;
      window_offset_in = window_offset_ff;
      window_length_in = window_length_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            ecwc_pkg::CSR_TARGET_BLOCK: begin
               target_block_in = csr_wdata[BLOCK_BITS-1:0];
            end
            ecwc_pkg::CSR_WINDOW_OFFSET: begin
               window_offset_in = csr_wdata[OFFSET_BITS-1:0];
            end
            ecwc_pkg::CSR_WINDOW_LENGTH: begin
               window_length_in = csr_wdata[OFFSET_BITS-1:0];
            end
            default: begin
            end
         endcase
      end
      window_end_in = {1'b0, window_offset_in} + {1'b0, window_length_in};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         target_block_ff  <= '0;
         window_offset_ff <= '0;
         window_length_ff <= '0;
         window_end_ff    <= '0;
      end else begin
         target_block_ff  <= target_block_in;
         window_offset_ff <= window_offset_in;
         window_length_ff <= window_length_in;
         window_end_ff    <= window_end_in;
      end
   end

   assign target_block  = target_block_ff;
   assign window_offset = window_offset_ff;
   assign window_end    = window_end_ff;

endmodule

// ===== rtl/core/ecwc_merge.sv =====
// ----------------------------------------------------------------------------
// ecwc_merge
// Pending extent holder. Folds same-block tail extensions, contained extents and
// head extensions into it; any other extent or a flush loads the emit register.
// ----------------------------------------------------------------------------
module ecwc_merge #(
   parameter int OFFSET_BITS = 48,
   parameter int BLOCK_BITS  = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic                   req_cmd,
   input  logic [BLOCK_BITS-1:0]  req_block_id,
   input  logic [OFFSET_BITS-1:0] req_start_offset,
   input  logic [OFFSET_BITS-1:0] req_extent_length,
   output logic                   emit_valid,
   input  logic                   emit_stall,
   output logic [BLOCK_BITS-1:0]  emit_block,
   output logic [OFFSET_BITS-1:0] emit_start,
   output logic [OFFSET_BITS:0]   emit_end
);

   logic                   pend_valid_ff, pend_valid_in;
   logic [BLOCK_BITS-1:0]  pend_block_ff, pend_block_in;
   logic [OFFSET_BITS-1:0] pend_start_ff, pend_start_in;
   logic [OFFSET_BITS:0]   pend_end_ff,   pend_end_in;

   logic                   emit_valid_ff, emit_valid_in;
   logic [BLOCK_BITS-1:0]  emit_block_ff, emit_block_in;
   logic [OFFSET_BITS-1:0] emit_start_ff, emit_start_in;
   logic [OFFSET_BITS:0]   emit_end_ff,   emit_end_in;

   logic                   accept;
   logic                   is_flush;
   logic                   same_block;
   logic                   tail_ext;
   logic                   contained;
   logic                   head_ext;
   logic                   emit_load;
   logic [OFFSET_BITS:0]   new_start;
   logic [OFFSET_BITS:0]   new_end;
   logic [OFFSET_BITS:0]   pend_start_w;

   assign req_stall = emit_valid_ff && emit_stall;
   assign accept    = req_valid && !req_stall;
   assign is_flush  = ecwc_pkg::cmd_type'(req_cmd) == ecwc_pkg::CMD_FLUSH;

   assign new_start    = {1'b0, req_start_offset};
   assign new_end      = {1'b0, req_start_offset} + {1'b0, req_extent_length};
   assign pend_start_w = {1'b0, pend_start_ff};

   assign same_block = pend_valid_ff && (pend_block_ff == req_block_id);
   assign tail_ext   = (pend_start_w < new_start) && (pend_end_ff >= new_start)
                       && (pend_end_ff <= new_end);
   assign contained  = (new_start >= pend_start_w) && (new_end <= pend_end_ff);
   assign head_ext   = (new_start <= pend_start_w) && (pend_start_w <= new_end)
                       && (new_end < pend_end_ff);

   always_comb begin
      pend_valid_in = pend_valid_ff;
      pend_block_in = pend_block_ff;
      pend_start_in = pend_start_ff;
      pend_end_in   = pend_end_ff;
      emit_load     = 1'b0;
      if (accept) begin
         priority if (is_flush) begin
            emit_load     = pend_valid_ff;
            pend_valid_in = 1'b0;
         end else if (same_block && tail_ext) begin
            pend_end_in = new_end;
         end else if (same_block && contained) begin
            pend_end_in = pend_end_ff;
         end else if (same_block && head_ext) begin
            pend_start_in = req_start_offset;
         end else begin
            emit_load     = pend_valid_ff;
            pend_valid_in = 1'b1;
            pend_block_in = req_block_id;
            pend_start_in = req_start_offset;
            pend_end_in   = new_end;
         end
      end
   end

   always_comb begin
      emit_valid_in = emit_valid_ff && emit_stall;
      emit_block_in = emit_block_ff;
      emit_start_in = emit_start_ff;
      emit_end_in   = emit_end_ff;
      if (emit_load) begin
         emit_valid_in = 1'b1;
         emit_block_in = pend_block_ff;
         emit_start_in = pend_start_ff;
         emit_end_in   = pend_end_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
         emit_valid_ff <= 1'b0;
      end else begin
         pend_valid_ff <= pend_valid_in;
         emit_valid_ff <= emit_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_block_ff <= pend_block_in;
      pend_start_ff <= pend_start_in;
      pend_end_ff   <= pend_end_in;
      emit_block_ff <= emit_block_in;
      emit_start_ff <= emit_start_in;
      emit_end_ff   <= emit_end_in;
   end

   assign emit_valid = emit_valid_ff;
   assign emit_block = emit_block_ff;
   assign emit_start = emit_start_ff;
   assign emit_end   = emit_end_ff;

   a_pend_ordered: assert property (@(posedge clock) disable iff (reset)
      pend_valid_ff |-> (pend_end_ff >= {1'b0, pend_start_ff}))
      else $error("pending extent end below its start");

   a_flush_empties: assert property (@(posedge clock) disable iff (reset)
      (accept && is_flush) |=> !pend_valid_ff)
      else $error("pending extent survives a flush");

endmodule

// ===== rtl/core/ecwc_carve.sv =====
// ----------------------------------------------------------------------------
// ecwc_carve
// Window carve-out on the emitted extent and the result register. Holds a
// head piece and a tail piece and presents them one transaction at a time.
// ----------------------------------------------------------------------------
module ecwc_carve #(
   parameter int OFFSET_BITS = 48,
   parameter int BLOCK_BITS  = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [BLOCK_BITS-1:0]  target_block,
   input  logic [OFFSET_BITS-1:0] window_offset,
   input  logic [OFFSET_BITS:0]   window_end,
   input  logic                   emit_valid,
   output logic                   emit_stall,
   input  logic [BLOCK_BITS-1:0]  emit_block,
   input  logic [OFFSET_BITS-1:0] emit_start,
   input  logic [OFFSET_BITS:0]   emit_end,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [BLOCK_BITS-1:0]  rsp_out_block,
   output logic [OFFSET_BITS:0]   rsp_out_offset,
   output logic [OFFSET_BITS:0]   rsp_out_length,
   output logic                   rsp_last
);

   ecwc_pkg::piece_set_type set_ff, set_in, carve_set;

   logic [BLOCK_BITS-1:0]  block_ff,    block_in;
   logic [OFFSET_BITS-1:0] start_ff,    start_in;
   logic [OFFSET_BITS:0]   head_len_ff, head_len_in;
   logic [OFFSET_BITS:0]   tail_off_ff, tail_off_in;
   logic [OFFSET_BITS:0]   tail_len_ff, tail_len_in;

   logic [OFFSET_BITS:0]   ext_start;
   logic [OFFSET_BITS:0]   win_start;
   logic [OFFSET_BITS:0]   whole_len;
   logic [OFFSET_BITS:0]   cut_len;
   logic [OFFSET_BITS:0]   carve_head_len;
   logic                   take;
   logic                   load;

   assign ext_start = {1'b0, emit_start};
   assign win_start = {1'b0, window_offset};
   assign whole_len = emit_end - ext_start;
   assign cut_len   = win_start - ext_start;

   always_comb begin
      carve_set      = '0;
      carve_head_len = whole_len;
      priority if (emit_block != target_block) begin
         carve_set.head = 1'b1;
      end else if ((win_start <= ext_start) && (window_end >= emit_end)) begin
         carve_set = '0;
      end else if ((win_start >= ext_start) && (window_end <= emit_end)) begin
         carve_set.head = win_start > ext_start;
         carve_set.tail = 1'b1;
         carve_head_len = cut_len;
      end else if ((win_start <= ext_start) && (window_end >= ext_start)
                   && (window_end <= emit_end)) begin
         carve_set.tail = 1'b1;
      end else if ((win_start >= ext_start) && (win_start <= emit_end)
                   && (window_end >= emit_end)) begin
         carve_set.head = win_start > ext_start;
         carve_head_len = cut_len;
      end else begin
         carve_set.head = 1'b1;
      end
   end

   assign rsp_valid  = set_ff.head || set_ff.tail;
   assign rsp_last   = !(set_ff.head && set_ff.tail);
   assign take       = rsp_valid && !rsp_stall;
   assign emit_stall = rsp_valid && !(take && rsp_last);
   assign load       = emit_valid && !emit_stall;

   always_comb begin
      set_in      = set_ff;
      block_in    = block_ff;
      start_in    = start_ff;
      head_len_in = head_len_ff;
      tail_off_in = tail_off_ff;
      tail_len_in = tail_len_ff;
      priority if (load) begin
         set_in      = carve_set;
         block_in    = emit_block;
         start_in    = emit_start;
         head_len_in = carve_head_len;
         tail_off_in = window_end;
         tail_len_in = emit_end - window_end;
      end else if (take && set_ff.head) begin
         set_in.head = 1'b0;
      end else if (take) begin
         set_in.tail = 1'b0;
      end else begin
         set_in = set_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         set_ff <= '0;
      end else begin
         set_ff <= set_in;
      end
   end

   always_ff @(posedge clock) begin
      block_ff    <= block_in;
      start_ff    <= start_in;
      head_len_ff <= head_len_in;
      tail_off_ff <= tail_off_in;
      tail_len_ff <= tail_len_in;
   end

   assign rsp_out_block  = block_ff;
   assign rsp_out_offset = set_ff.head ? {1'b0, start_ff} : tail_off_ff;
   assign rsp_out_length = set_ff.head ? head_len_ff : tail_len_ff;

   a_second_piece: assert property (@(posedge clock) disable iff (reset)
      (take && !rsp_last) |=> (rsp_valid && rsp_last))
      else $error("tail piece lost after head piece");

   a_tail_inside: assert property (@(posedge clock) disable iff (reset)
      set_ff.tail |-> (tail_off_ff >= {1'b0, start_ff}))
      else $error("tail piece starts before its extent");

endmodule

// ===== rtl/core/extent_coalesce_window_carve_core.sv =====
// ----------------------------------------------------------------------------
// extent_coalesce_window_carve_core
// Extent coalescer with target window carve-out.
// ----------------------------------------------------------------------------
// Takes one request transaction per cycle while req_stall is low. Each extent
// is merged against the single pending extent in the cycle it is accepted; an
// extent that leaves the holder goes to the emit register and is carved against
// the window as it moves into the result register, which presents its pieces.
// An extent carved into a head and a tail piece is presented as two response
// transactions, head first; one wholly inside the target window gives none and
// every other case one. The window end is registered together with the control
// registers, so a control write applies to every carve after its clock edge.
// ----------------------------------------------------------------------------
module extent_coalesce_window_carve_core #(
   parameter int OFFSET_BITS = 48,
   parameter int BLOCK_BITS  = 32
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      req_valid,
   output logic                                      req_stall,
   input  logic                                      req_cmd,
   input  logic [BLOCK_BITS-1:0]                     req_block_id,
   input  logic [OFFSET_BITS-1:0]                    req_start_offset,
   input  logic [OFFSET_BITS-1:0]                    req_extent_length,
   output logic                                      rsp_valid,
   input  logic                                      rsp_stall,
   output logic [BLOCK_BITS-1:0]                     rsp_out_block,
   output logic [OFFSET_BITS:0]                      rsp_out_offset,
   output logic [OFFSET_BITS:0]                      rsp_out_length,
   output logic                                      rsp_last,
   input  logic                                      csr_valid,
   output logic                                      csr_ready,
   input  logic [ecwc_pkg::CSR_INDEX_BITS-1:0]       csr_index,
   input  logic [(BLOCK_BITS > OFFSET_BITS ? BLOCK_BITS : OFFSET_BITS)-1:0] csr_wdata
);

   logic [BLOCK_BITS-1:0]  target_block;
   logic [OFFSET_BITS-1:0] window_offset;
   logic [OFFSET_BITS:0]   window_end;

   logic                   emit_valid;
   logic                   emit_stall;
   logic [BLOCK_BITS-1:0]  emit_block;
   logic [OFFSET_BITS-1:0] emit_start;
   logic [OFFSET_BITS:0]   emit_end;

   ecwc_csr #(
      .OFFSET_BITS (OFFSET_BITS),
      .BLOCK_BITS  (BLOCK_BITS)
   ) u_csr (
      .clock         (clock),
      .reset         (reset),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .target_block  (target_block),
      .window_offset (window_offset),
      .window_end    (window_end)
   );

   ecwc_merge #(
      .OFFSET_BITS (OFFSET_BITS),
      .BLOCK_BITS  (BLOCK_BITS)
   ) u_merge (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_cmd           (req_cmd),
      .req_block_id      (req_block_id),
      .req_start_offset  (req_start_offset),
      .req_extent_length (req_extent_length),
      .emit_valid        (emit_valid),
      .emit_stall        (emit_stall),
      .emit_block        (emit_block),
      .emit_start        (emit_start),
      .emit_end          (emit_end)
   );

   ecwc_carve #(
      .OFFSET_BITS (OFFSET_BITS),
      .BLOCK_BITS  (BLOCK_BITS)
   ) u_carve (
      .clock          (clock),
      .reset          (reset),
      .target_block   (target_block),
      .window_offset  (window_offset),
      .window_end     (window_end),
      .emit_valid     (emit_valid),
      .emit_stall     (emit_stall),
      .emit_block     (emit_block),
      .emit_start     (emit_start),
      .emit_end       (emit_end),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_out_block  (rsp_out_block),
      .rsp_out_offset (rsp_out_offset),
      .rsp_out_length (rsp_out_length),
      .rsp_last       (rsp_last)
   );

endmodule

// ===== dv/extent_coalesce_window_carve_core_tb.sv =====
// ----------------------------------------------------------------------------
// extent_coalesce_window_carve_core_tb
// Self-checking testbench for the extent coalesce and window carve core.
// ----------------------------------------------------------------------------
// Extents and flushes are sent through the request channel while an
// in-bench predictor folds each accepted transaction into its own held
// extent and queues the carved pieces it expects. The response monitor
// compares every accepted piece field by field against the oldest queued
// piece. Directed merge, carve and field-extreme sequences come first,
// then mostly localized random traffic under several window settings, with the
// sender and receiver idling at random except in the last two settings.
// ----------------------------------------------------------------------------
module extent_coalesce_window_carve_core_tb;

   localparam int OFFSET_BITS = 48;
   localparam int BLOCK_BITS  = 32;
   localparam int WIDE_BITS   = OFFSET_BITS + 1;
   localparam int DATA_BITS   = 48;
   localparam logic [OFFSET_BITS-1:0] OFFSET_MAX = '1;
   localparam logic [BLOCK_BITS-1:0]  BLOCK_MAX  = '1;

   typedef struct {
      logic [BLOCK_BITS-1:0] blk;
      logic [WIDE_BITS-1:0]  offset;
      logic [WIDE_BITS-1:0]  length;
      logic                  last;
   } piece_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_stall;
   ecwc_pkg::cmd_type       req_cmd = ecwc_pkg::CMD_EXTENT;
   logic [BLOCK_BITS-1:0]   req_block_id = '0;
   logic [OFFSET_BITS-1:0]  req_start_offset = '0;
   logic [OFFSET_BITS-1:0]  req_extent_length = '0;
   logic                    rsp_valid;
   logic                    rsp_stall = 1'b0;
   logic [BLOCK_BITS-1:0]   rsp_out_block;
   logic [OFFSET_BITS:0]    rsp_out_offset;
   logic [OFFSET_BITS:0]    rsp_out_length;
   logic                    rsp_last;
   logic                    csr_valid = 1'b0;
   logic                    csr_ready;
   ecwc_pkg::csr_index_type csr_index = ecwc_pkg::CSR_TARGET_BLOCK;
   logic [DATA_BITS-1:0]    csr_wdata = '0;

   int send_idle_pct = 7;
   int recv_stall_pct = 71;
   int mismatch_count = 0;
   logic [OFFSET_BITS-1:0] region_base = '0;

   logic [BLOCK_BITS-1:0]  win_target = '0;
   logic [OFFSET_BITS-1:0] win_offset = '0;
   logic [OFFSET_BITS-1:0] win_length = '0;
   logic                   held_valid = 1'b0;
   logic [BLOCK_BITS-1:0]  held_block = '0;
   logic [OFFSET_BITS-1:0] held_start = '0;
   logic [WIDE_BITS-1:0]   held_len = '0;

   piece_type carved_pieces[$];

   extent_coalesce_window_carve_core #(
      .OFFSET_BITS(OFFSET_BITS),
      .BLOCK_BITS(BLOCK_BITS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_cmd(req_cmd),
      .req_block_id(req_block_id),
      .req_start_offset(req_start_offset),
      .req_extent_length(req_extent_length),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_out_block(rsp_out_block),
      .rsp_out_offset(rsp_out_offset),
      .rsp_out_length(rsp_out_length),
      .rsp_last(rsp_last),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("*** FAILED ***");
      $finish;
   end

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      $display("ERROR at %0t: %s got %h expected %h", $time, what, got, want);
      mismatch_count++;
   endtask

   function automatic piece_type make_piece(logic [WIDE_BITS:0] offset,
                                            logic [WIDE_BITS:0] length);
      piece_type p;
      p.blk = held_block;
      p.offset = offset[WIDE_BITS-1:0];
      p.length = length[WIDE_BITS-1:0];
      p.last = 1'b0;
      return p;
   endfunction

   function automatic void carve_held_extent();
      logic [WIDE_BITS:0] o, e, ws, we;
      piece_type pcs[2];
      int n;
      o = {2'b0, held_start};
      e = o + {1'b0, held_len};
      ws = {2'b0, win_offset};
      we = ws + {2'b0, win_length};
      n = 0;
      if (held_block != win_target) begin
         pcs[n++] = make_piece(o, {1'b0, held_len});
      end else if (ws <= o && we >= e) begin
      end else if (ws >= o && we <= e) begin
         if (ws > o) pcs[n++] = make_piece(o, ws - o);
         pcs[n++] = make_piece(we, e - we);
      end else if (ws <= o && we >= o && we <= e) begin
         pcs[n++] = make_piece(we, e - we);
      end else if (ws >= o && ws <= e && we >= e) begin
         if (ws > o) pcs[n++] = make_piece(o, ws - o);
      end else begin
         pcs[n++] = make_piece(o, {1'b0, held_len});
      end
      if (n > 0) pcs[n-1].last = 1'b1;
      for (int i = 0; i < n; i++) carved_pieces.push_back(pcs[i]);
   endfunction

   function automatic void fold_extent(ecwc_pkg::cmd_type cmd, logic [BLOCK_BITS-1:0] blk,
                                       logic [OFFSET_BITS-1:0] ofs,
                                       logic [OFFSET_BITS-1:0] len);
      logic [WIDE_BITS:0] ns, ne, ps, pe;
      ns = {2'b0, ofs};
      ne = ns + {2'b0, len};
      if (cmd == ecwc_pkg::CMD_FLUSH) begin
         if (held_valid) carve_held_extent();
         held_valid = 1'b0;
         return;
      end
      if (held_valid && held_block == blk) begin
         ps = {2'b0, held_start};
         pe = ps + {1'b0, held_len};
         if (ps < ns && pe >= ns && pe <= ne) begin
            held_len = WIDE_BITS'(ne - ps);
            return;
         end
         if (ns >= ps && ne <= pe) return;
         if (ns <= ps && ps <= ne && ne < pe) begin
            held_start = ofs;
            held_len = WIDE_BITS'(pe - ns);
            return;
         end
      end
      if (held_valid) carve_held_extent();
      held_valid = 1'b1;
      held_block = blk;
      held_start = ofs;
      held_len = {1'b0, len};
   endfunction

   always @(posedge clock) begin
      piece_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (carved_pieces.size() == 0) begin
            report_mismatch("unexpected transaction, block", 64'(rsp_out_block), '0);
         end else begin
            want = carved_pieces.pop_front();
            if (rsp_out_block !== want.blk)
               report_mismatch("out_block", 64'(rsp_out_block), 64'(want.blk));
            if (rsp_out_offset !== want.offset)
               report_mismatch("out_offset", 64'(rsp_out_offset), 64'(want.offset));
            if (rsp_out_length !== want.length)
               report_mismatch("out_length", 64'(rsp_out_length), 64'(want.length));
            if (rsp_last !== want.last)
               report_mismatch("last", 64'(rsp_last), 64'(want.last));
         end
      end
      rsp_stall <= ($urandom_range(99) < recv_stall_pct);
   end

   function automatic logic [OFFSET_BITS-1:0] rand_offset();
      logic [63:0] r;
      r = {$urandom, $urandom};
      return r[OFFSET_BITS-1:0];
   endfunction

   task automatic send_item(ecwc_pkg::cmd_type cmd, logic [BLOCK_BITS-1:0] blk,
                            logic [OFFSET_BITS-1:0] ofs, logic [OFFSET_BITS-1:0] len);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_cmd <= cmd;
      req_block_id <= blk;
      req_start_offset <= ofs;
      req_extent_length <= len;
      do @(posedge clock); while (req_stall);
      fold_extent(cmd, blk, ofs, len);
   endtask

   task automatic write_register(ecwc_pkg::csr_index_type idx, logic [DATA_BITS-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         ecwc_pkg::CSR_TARGET_BLOCK:  win_target = data[BLOCK_BITS-1:0];
         ecwc_pkg::CSR_WINDOW_OFFSET: win_offset = data[OFFSET_BITS-1:0];
         ecwc_pkg::CSR_WINDOW_LENGTH: win_length = data[OFFSET_BITS-1:0];
         default: ;
      endcase
   endtask

   task automatic configure_window(logic [BLOCK_BITS-1:0] blk, logic [OFFSET_BITS-1:0] ofs,
                                   logic [OFFSET_BITS-1:0] len);
      write_register(ecwc_pkg::CSR_TARGET_BLOCK, DATA_BITS'(blk));
      write_register(ecwc_pkg::CSR_WINDOW_OFFSET, ofs);
      write_register(ecwc_pkg::CSR_WINDOW_LENGTH, len);
      csr_valid <= 1'b0;
      repeat (3) @(posedge clock);
   endtask

   task automatic drain_results();
      int guard;
      guard = 0;
      req_valid <= 1'b0;
      while (carved_pieces.size() > 0 && guard < 50000) begin
         @(posedge clock);
         guard++;
      end
      if (carved_pieces.size() > 0) begin
         report_mismatch("missing transactions, count", 64'(carved_pieces.size()), '0);
         carved_pieces.delete();
      end
      repeat (8) @(posedge clock);
   endtask

   task automatic test_merge_rules();
      send_item(ecwc_pkg::CMD_EXTENT, 5, 900, 50);
      send_item(ecwc_pkg::CMD_EXTENT, 5, 920, 100);
      send_item(ecwc_pkg::CMD_EXTENT, 5, 950, 10);
      send_item(ecwc_pkg::CMD_EXTENT, 5, 850, 60);
      send_item(ecwc_pkg::CMD_FLUSH, 5, 0, 0);
      send_item(ecwc_pkg::CMD_FLUSH, 5, 0, 0);
   endtask

   task automatic test_carve_rules();
      send_item(ecwc_pkg::CMD_EXTENT, 5, 1000, 100);
      send_item(ecwc_pkg::CMD_FLUSH, 0, 0, 0);
      send_item(ecwc_pkg::CMD_EXTENT, 5, 900, 300);
      send_item(ecwc_pkg::CMD_FLUSH, 0, 0, 0);
      send_item(ecwc_pkg::CMD_EXTENT, 5, 1000, 200);
      send_item(ecwc_pkg::CMD_FLUSH, 0, 0, 0);
      send_item(ecwc_pkg::CMD_EXTENT, 5, 900, 200);
      send_item(ecwc_pkg::CMD_FLUSH, 0, 0, 0);
      send_item(ecwc_pkg::CMD_EXTENT, 5, 1050, 100);
      send_item(ecwc_pkg::CMD_FLUSH, 0, 0, 0);
      send_item(ecwc_pkg::CMD_EXTENT, 5, 0, 10);
   endtask

   task automatic test_field_extremes();
      send_item(ecwc_pkg::CMD_EXTENT, 9, 0, 10);
      send_item(ecwc_pkg::CMD_EXTENT, 9, 0, 20);
      send_item(ecwc_pkg::CMD_EXTENT, BLOCK_MAX, OFFSET_MAX, OFFSET_MAX);
      send_item(ecwc_pkg::CMD_EXTENT, 0, 0, 0);
      send_item(ecwc_pkg::CMD_FLUSH, BLOCK_MAX, OFFSET_MAX, OFFSET_MAX);
   endtask

   task automatic test_random_traffic(int count);
      logic [BLOCK_BITS-1:0]  blk;
      logic [OFFSET_BITS-1:0] ofs, len;
      int pick;
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(99) < 12) begin
            send_item(ecwc_pkg::CMD_FLUSH, $urandom, rand_offset(), rand_offset());
         end else begin
            pick = $urandom_range(99);
            if (pick < 50) blk = win_target;
            else if (pick < 70) blk = win_target + 1;
            else if (pick < 90) blk = $urandom_range(0, 3);
            else blk = $urandom;
            if ($urandom_range(99) < 85) begin
               ofs = region_base + OFFSET_BITS'($urandom_range(0, 3999));
               len = OFFSET_BITS'($urandom_range(0, 800));
            end else begin
               ofs = rand_offset();
               len = rand_offset() >> $urandom_range(0, OFFSET_BITS - 1);
            end
            send_item(ecwc_pkg::CMD_EXTENT, blk, ofs, len);
         end
      end
      drain_results();
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      configure_window(5, 1000, 100);
      test_merge_rules();
      test_carve_rules();
      test_field_extremes();
      drain_results();

      configure_window(1, 2000, 500);
      region_base = '0;
      test_random_traffic(105);
      configure_window(0, 0, 0);
      test_random_traffic(105);

      send_idle_pct = 71;
      recv_stall_pct = 7;
      configure_window(BLOCK_MAX, OFFSET_MAX, OFFSET_MAX);
      region_base = OFFSET_MAX - 48'd4095;
      test_random_traffic(105);
      configure_window(2, 1500, 3000);
      region_base = '0;
      test_random_traffic(105);

      send_idle_pct = 0;
      recv_stall_pct = 0;
      configure_window(3, 0, OFFSET_MAX);
      test_random_traffic(105);
      configure_window(1, 2500, 1);
      test_random_traffic(105);

      if (mismatch_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
